@@ sv/sphf_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the sph pair force pipeline
// no dependencies; used by every module of the block

package sphf_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int D2_BITS   = 2 * WORD_BITS - 2;

   // configuration register indexes
   localparam logic [1:0] REG_KERNEL_RANGE = 2'd0;
   localparam logic [1:0] REG_SPIKY_GRAD   = 2'd1;
   localparam logic [1:0] REG_VISC_LAP     = 2'd2;
   localparam logic [1:0] REG_VISCOSITY    = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_SKIP  = 2'd1;
   localparam logic [1:0] STATUS_FAULT = 2'd2;

   // register reset values
   localparam logic [WORD_BITS-2:0] KERNEL_RANGE_RESET = (WORD_BITS-1)'(65536);
   localparam logic [WORD_BITS-1:0] SPIKY_GRAD_RESET   = WORD_BITS'(-625824);
   localparam logic [WORD_BITS-1:0] VISC_LAP_RESET     = WORD_BITS'(258958);
   localparam logic [WORD_BITS-1:0] VISCOSITY_RESET    = '0;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] rel_pos_x;
      logic signed [WORD_BITS-1:0] rel_pos_y;
      logic signed [WORD_BITS-1:0] rel_vel_x;
      logic signed [WORD_BITS-1:0] rel_vel_y;
      logic [WORD_BITS-2:0]        neighbor_mass;
      logic signed [WORD_BITS-1:0] own_pressure;
      logic signed [WORD_BITS-1:0] neighbor_pressure;
      logic [WORD_BITS-2:0]        own_density;
      logic [WORD_BITS-2:0]        neighbor_density;
      logic                        neighbor_is_boundary;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] force_x;
      logic signed [WORD_BITS-1:0] force_y;
      logic [1:0]                  status;
   } rsp_type;

   // per-pair context carried down the pipeline
   typedef struct packed {
      logic [WORD_BITS-1:0] px;
      logic [WORD_BITS-1:0] py;
      logic [WORD_BITS-1:0] vx;
      logic [WORD_BITS-1:0] vy;
      logic [WORD_BITS-2:0] mass;
      logic [WORD_BITS-2:0] rho_own;
      logic [WORD_BITS-2:0] rho_nb;
      logic [WORD_BITS:0]   psum;
      logic                 pon;
      logic                 von;
      logic                 skip;
      logic [1:0]           status;
      logic [D2_BITS-1:0]   d2;
      logic [WORD_BITS-2:0] root_dist;
      logic [WORD_BITS-1:0] rmd;
      logic [WORD_BITS-1:0] t;
      logic [WORD_BITS-1:0] u;
   } ctx_type;

endpackage

@@ sv/sphf_mulq.sv @@
`timescale 1ns / 1ps
// two-stage fixed point multiplier lanes: product, then shift and saturate
// depends on sphf_pkg

module sphf_mulq #(
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [LANES-1:0][sphf_pkg::WORD_BITS:0]       in_a,
   input  logic [LANES-1:0][sphf_pkg::WORD_BITS:0]       in_b,
   input  logic [SIDE_W-1:0]                             in_side,
   output logic                                          out_valid,
   output logic [LANES-1:0][sphf_pkg::WORD_BITS-1:0]     out_res,
   output logic [SIDE_W-1:0]                             out_side
);

   localparam int W  = sphf_pkg::WORD_BITS;
   localparam int F  = sphf_pkg::FRAC_BITS;
   localparam int PW = 2 * W + 2;

   logic [LANES-1:0][W:0]    mag_a;
   logic [LANES-1:0][W:0]    mag_b;
   logic [LANES-1:0]         neg_in;
   logic [LANES-1:0]         neg_ff;
   logic [LANES-1:0][PW-1:0] prod_in;
   logic [LANES-1:0][PW-1:0] prod_ff;
   logic [LANES-1:0][PW-1:0] shf;
   logic [LANES-1:0][PW-1:0] lim;
   logic [LANES-1:0][PW-1:0] mv;
   logic [LANES-1:0][W-1:0]  res_in;
   logic [LANES-1:0][W-1:0]  res_ff;
   logic                     p_valid_ff;
   logic                     r_valid_ff;
   logic [SIDE_W-1:0]        p_side_ff;
   logic [SIDE_W-1:0]        r_side_ff;

   // magnitudes and full product
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mag_a[l]   = in_a[l][W] ? (~in_a[l] + (W+1)'(1)) : in_a[l];
         mag_b[l]   = in_b[l][W] ? (~in_b[l] + (W+1)'(1)) : in_b[l];
         neg_in[l]  = in_a[l][W] ^ in_b[l][W];
         prod_in[l] = PW'(mag_a[l]) * PW'(mag_b[l]);
      end
   end

   // drop fraction bits, saturate, restore sign
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         shf[l]    = prod_ff[l] >> F;
         lim[l]    = (PW'(1) << (W - 1)) - (neg_ff[l] ? PW'(0) : PW'(1));
         mv[l]     = (shf[l] > lim[l]) ? lim[l] : shf[l];
         res_in[l] = neg_ff[l] ? (~mv[l][W-1:0] + W'(1)) : mv[l][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
         r_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      neg_ff    <= neg_in;
      p_side_ff <= in_side;
      res_ff    <= res_in;
      r_side_ff <= p_side_ff;
   end

   assign out_valid = r_valid_ff;
   assign out_res   = res_ff;
   assign out_side  = r_side_ff;

endmodule

@@ sv/sphf_divq.sv @@
`timescale 1ns / 1ps
// pipelined fixed point divider lanes, one quotient bit per stage, saturating
// depends on sphf_pkg

module sphf_divq #(
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [LANES-1:0][sphf_pkg::WORD_BITS-1:0]     in_a,
   input  logic [LANES-1:0][sphf_pkg::WORD_BITS-1:0]     in_d,
   input  logic [SIDE_W-1:0]                             in_side,
   output logic                                          out_valid,
   output logic [LANES-1:0][sphf_pkg::WORD_BITS-1:0]     out_res,
   output logic [SIDE_W-1:0]                             out_side
);

   localparam int W  = sphf_pkg::WORD_BITS;
   localparam int F  = sphf_pkg::FRAC_BITS;
   localparam int RW = 2 * W;
   localparam int QW = W - 1;

   logic [W-1:0]                v_ff;
   logic [SIDE_W-1:0]           side_ff [W];
   logic [LANES-1:0][RW-1:0]    rem_in  [W-1];
   logic [LANES-1:0][RW-1:0]    rem_ff  [W-1];
   logic [LANES-1:0][W-1:0]     dv_ff   [W-1];
   logic [LANES-1:0][QW-1:0]    q_in    [W];
   logic [LANES-1:0][QW-1:0]    q_ff    [W];
   logic [LANES-1:0]            neg_in;
   logic [LANES-1:0]            neg_ff  [W];
   logic [LANES-1:0]            ovf_in;
   logic [LANES-1:0]            ovf_ff  [W];
   logic [LANES-1:0][W-1:0]     res_in;
   logic [LANES-1:0][W-1:0]     res_ff;
   logic                        o_valid_ff;
   logic [SIDE_W-1:0]           o_side_ff;

   // entry: magnitude, overflow check, then restoring steps
   always_comb begin
      logic [W-1:0]  mag;
      logic [RW-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
         mag          = in_a[l][W-1] ? (~in_a[l] + W'(1)) : in_a[l];
         neg_in[l]    = in_a[l][W-1];
         rem_in[0][l] = RW'(mag) << F;
         ovf_in[l]    = (RW'(mag) << F) >= (RW'(in_d[l]) << (W - 1));
         q_in[0][l]   = '0;
      end
      for (int i = 1; i < W - 1; i++) begin
         for (int l = 0; l < LANES; l++) begin
            trial = RW'(dv_ff[i-1][l]) << (W - 1 - i);
            if (rem_ff[i-1][l] >= trial) begin
               rem_in[i][l] = rem_ff[i-1][l] - trial;
               q_in[i][l]   = q_ff[i-1][l] | (QW'(1) << (W - 1 - i));
            end else begin
               rem_in[i][l] = rem_ff[i-1][l];
               q_in[i][l]   = q_ff[i-1][l];
            end
         end
      end
      // last step only needs the quotient bit
      for (int l = 0; l < LANES; l++) begin
         q_in[W-1][l] = q_ff[W-2][l] | ((rem_ff[W-2][l] >= RW'(dv_ff[W-2][l])) ? QW'(1) : QW'(0));
      end
   end

   // saturate and apply sign
   always_comb begin
      logic [W-1:0] lim;
      logic [W-1:0] qv;
      for (int l = 0; l < LANES; l++) begin
         lim       = neg_ff[W-1][l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         qv        = ovf_ff[W-1][l] ? lim : {1'b0, q_ff[W-1][l]};
         res_in[l] = neg_ff[W-1][l] ? (~qv + W'(1)) : qv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff       <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         v_ff       <= {v_ff[W-2:0], in_valid};
         o_valid_ff <= v_ff[W-1];
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      neg_ff[0]  <= neg_in;
      ovf_ff[0]  <= ovf_in;
      q_ff[0]    <= q_in[0];
      rem_ff[0]  <= rem_in[0];
      dv_ff[0]   <= in_d;
      for (int i = 1; i < W; i++) begin
         side_ff[i] <= side_ff[i-1];
         neg_ff[i]  <= neg_ff[i-1];
         ovf_ff[i]  <= ovf_ff[i-1];
         q_ff[i]    <= q_in[i];
      end
      for (int i = 1; i < W - 1; i++) begin
         rem_ff[i] <= rem_in[i];
         dv_ff[i]  <= dv_ff[i-1];
      end
      res_ff    <= res_in;
      o_side_ff <= side_ff[W-1];
   end

   assign out_valid = o_valid_ff;
   assign out_res   = res_ff;
   assign out_side  = o_side_ff;

endmodule

@@ sv/sphf_sqrt.sv @@
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage
// depends on sphf_pkg

module sphf_sqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [sphf_pkg::D2_BITS-1:0]      in_n,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic [sphf_pkg::WORD_BITS-2:0]    out_root,
   output logic [SIDE_W-1:0]                 out_side
);

   localparam int W  = sphf_pkg::WORD_BITS;
   localparam int SW = sphf_pkg::D2_BITS + 1;
   localparam int RB = W - 1;

   logic [W-1:0]      v_ff;
   logic [SIDE_W-1:0] side_ff [W];
   logic [SW-1:0]     rem_in  [W-1];
   logic [SW-1:0]     rem_ff  [W-1];
   logic [RB-1:0]     r_in    [W];
   logic [RB-1:0]     r_ff    [W];

   // remainder tracks n - r*r; test adds 2*r*2^b + 4^b
   always_comb begin
      logic [SW-1:0] trial;
      rem_in[0] = SW'(in_n);
      r_in[0]   = '0;
      for (int i = 1; i < W - 1; i++) begin
         trial = (SW'(r_ff[i-1]) << (W - i)) + (SW'(1) << (2 * (W - 1 - i)));
         if (rem_ff[i-1] >= trial) begin
            rem_in[i] = rem_ff[i-1] - trial;
            r_in[i]   = r_ff[i-1] | (RB'(1) << (W - 1 - i));
         end else begin
            rem_in[i] = rem_ff[i-1];
            r_in[i]   = r_ff[i-1];
         end
      end
      trial     = (SW'(r_ff[W-2]) << 1) + SW'(1);
      r_in[W-1] = r_ff[W-2] | ((rem_ff[W-2] >= trial) ? RB'(1) : RB'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
      r_ff[0]    <= r_in[0];
      rem_ff[0]  <= rem_in[0];
      for (int i = 1; i < W; i++) begin
         side_ff[i] <= side_ff[i-1];
         r_ff[i]    <= r_in[i];
      end
      for (int i = 1; i < W - 1; i++) begin
         rem_ff[i] <= rem_in[i];
      end
   end

   assign out_valid = v_ff[W-1];
   assign out_root  = r_ff[W-1];
   assign out_side  = side_ff[W-1];

endmodule

@@ sv/sph_pair_pressure_viscosity_force.sv @@
`timescale 1ns / 1ps
// top level of the sph pair pressure and viscosity force pipeline
// depends on sphf_pkg, sphf_mulq, sphf_divq, sphf_sqrt
//
//   channel   ports                          transfer when
//   request   start, busy, req_item          start high and busy low
//   result    rsp_valid, rsp_item            rsp_valid high (one cycle)
//   config    csr_valid, csr_ready, csr_*    csr_valid and csr_ready high
//
// one pair enters per cycle; busy stays low and csr_ready stays high
// three 33-stage dividers, a 32-stage square root, five two-stage multipliers
// and three single registers make up the pipeline
// synchronous reset clears the valid chain and restores register defaults
// the pipeline never stalls, each result appears for exactly one cycle

module sph_pair_pressure_viscosity_force (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  sphf_pkg::req_type                 req_item,
   output logic                              rsp_valid,
   output sphf_pkg::rsp_type                 rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [sphf_pkg::WORD_BITS-1:0]    csr_data
);

   localparam int W  = sphf_pkg::WORD_BITS;
   localparam int NB = sphf_pkg::D2_BITS;
   localparam int CW = $bits(sphf_pkg::ctx_type);

   logic [W-2:0] kernel_range_ff;
   logic [W-1:0] spiky_ff;
   logic [W-1:0] visc_lap_ff;
   logic [W-1:0] viscosity_ff;

   sphf_pkg::ctx_type a_ctx_in, a_ctx_ff;
   sphf_pkg::ctx_type b_ctx_in, b_ctx_ff;
   logic              a_valid_ff, b_valid_ff;
   logic [W-1:0]      mag_x, mag_y;
   logic [2*W-1:0]    sqx_in, sqx_ff, sqy_in, sqy_ff;
   logic [NB-1:0]     hh_in, hh_ff;
   logic [2*W:0]      d2_full;

   logic                  m1_valid, sq_valid, d1_valid, m2_valid, m3_valid;
   logic                  m4_valid, d2_valid, m5_valid, d3_valid;
   sphf_pkg::ctx_type     m1_ctx, c_ctx, sq_ctx, d_ctx, d1_ctx, e_ctx, m2_ctx, f_ctx;
   sphf_pkg::ctx_type     m3_ctx, g_ctx, m4_ctx, h_ctx, dv_ctx, i_ctx, m5_ctx, j_ctx;
   sphf_pkg::ctx_type     d3_ctx;
   logic [1:0][W:0]       m1_a, m1_b, m2_a, m2_b, m3_a, m3_b;
   logic [0:0][W:0]       m4_a, m4_b;
   logic [3:0][W:0]       m5_a, m5_b;
   logic [1:0][W-1:0]     m1_r, m2_r, m3_r, dv_r, d3_r;
   logic [0:0][W-1:0]     m4_r, d1_r;
   logic [3:0][W-1:0]     m5_r;
   logic [0:0][W-1:0]     d1_a, d1_d;
   logic [1:0][W-1:0]     dv_a, dv_d, d3_a, d3_d;
   logic [W-2:0]          root;
   logic [W-1:0]          ax, ay, bx, by;
   logic [W:0]            sx, sy;

   logic                  rsp_valid_ff;
   sphf_pkg::rsp_type     rsp_item_in, rsp_item_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_range_ff <= sphf_pkg::KERNEL_RANGE_RESET;
         spiky_ff        <= sphf_pkg::SPIKY_GRAD_RESET;
         visc_lap_ff     <= sphf_pkg::VISC_LAP_RESET;
         viscosity_ff    <= sphf_pkg::VISCOSITY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sphf_pkg::REG_KERNEL_RANGE: kernel_range_ff <= csr_data[W-2:0];
            sphf_pkg::REG_SPIKY_GRAD:   spiky_ff        <= csr_data;
            sphf_pkg::REG_VISC_LAP:     visc_lap_ff     <= csr_data;
            sphf_pkg::REG_VISCOSITY:    viscosity_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // stage a: capture pair, squares of position and range
   always_comb begin
      a_ctx_in         = '0;
      a_ctx_in.px      = req_item.rel_pos_x;
      a_ctx_in.py      = req_item.rel_pos_y;
      a_ctx_in.vx      = req_item.rel_vel_x;
      a_ctx_in.vy      = req_item.rel_vel_y;
      a_ctx_in.mass    = req_item.neighbor_mass;
      a_ctx_in.rho_own = req_item.own_density;
      a_ctx_in.rho_nb  = req_item.neighbor_density;
      a_ctx_in.psum    = {req_item.own_pressure[W-1], req_item.own_pressure}
                       + {req_item.neighbor_pressure[W-1], req_item.neighbor_pressure};
      a_ctx_in.pon     = !req_item.own_pressure[W-1] && (req_item.own_pressure != '0);
      a_ctx_in.von     = !viscosity_ff[W-1] && (viscosity_ff != '0);
      a_ctx_in.skip    = req_item.neighbor_is_boundary;
      mag_x  = req_item.rel_pos_x[W-1] ? (~req_item.rel_pos_x + W'(1)) : req_item.rel_pos_x;
      mag_y  = req_item.rel_pos_y[W-1] ? (~req_item.rel_pos_y + W'(1)) : req_item.rel_pos_y;
      sqx_in = (2*W)'(mag_x) * (2*W)'(mag_x);
      sqy_in = (2*W)'(mag_y) * (2*W)'(mag_y);
      hh_in  = NB'(kernel_range_ff) * NB'(kernel_range_ff);
   end

   // stage b: squared distance and range test
   always_comb begin
      d2_full       = (2*W+1)'(sqx_ff) + (2*W+1)'(sqy_ff);
      b_ctx_in      = a_ctx_ff;
      b_ctx_in.d2   = d2_full[NB-1:0];
      b_ctx_in.skip = a_ctx_ff.skip || (d2_full >= (2*W+1)'(hh_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ctx_ff <= a_ctx_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      hh_ff    <= hh_in;
      b_ctx_ff <= b_ctx_in;
   end

   // mass times pressure sum, viscosity times mass
   assign m1_a[0] = {2'b00, b_ctx_ff.mass};
   assign m1_b[0] = b_ctx_ff.psum;
   assign m1_a[1] = {viscosity_ff[W-1], viscosity_ff};
   assign m1_b[1] = {2'b00, b_ctx_ff.mass};

   sphf_mulq #(.LANES(2), .SIDE_W(CW)) u_mul1 (
      .clock(clock), .reset(reset), .in_valid(b_valid_ff), .in_a(m1_a), .in_b(m1_b),
      .in_side(b_ctx_ff), .out_valid(m1_valid), .out_res(m1_r), .out_side(m1_ctx)
   );

   always_comb begin
      c_ctx   = m1_ctx;
      c_ctx.t = m1_r[0];
      c_ctx.u = m1_r[1];
   end

   // distance
   sphf_sqrt #(.SIDE_W(CW)) u_sqrt (
      .clock(clock), .reset(reset), .in_valid(m1_valid), .in_n(c_ctx.d2),
      .in_side(c_ctx), .out_valid(sq_valid), .out_root(root), .out_side(sq_ctx)
   );

   // remaining range, status decision
   always_comb begin
      d_ctx           = sq_ctx;
      d_ctx.root_dist = root;
      d_ctx.rmd       = {1'b0, kernel_range_ff} - {1'b0, root};
      if (sq_ctx.skip) begin
         d_ctx.status = sphf_pkg::STATUS_SKIP;
      end else if ((sq_ctx.rho_own == '0)
                   || ((sq_ctx.pon || sq_ctx.von) && (sq_ctx.rho_nb == '0))
                   || (sq_ctx.pon && (root == '0))) begin
         d_ctx.status = sphf_pkg::STATUS_FAULT;
      end else begin
         d_ctx.status = sphf_pkg::STATUS_OK;
      end
   end

   // pressure term over twice the neighbor density
   assign d1_a[0] = d_ctx.t;
   assign d1_d[0] = {d_ctx.rho_nb, 1'b0};

   sphf_divq #(.LANES(1), .SIDE_W(CW)) u_div1 (
      .clock(clock), .reset(reset), .in_valid(sq_valid), .in_a(d1_a), .in_d(d1_d),
      .in_side(d_ctx), .out_valid(d1_valid), .out_res(d1_r), .out_side(d1_ctx)
   );

   always_comb begin
      e_ctx   = d1_ctx;
      e_ctx.t = d1_r[0];
   end

   // kernel coefficients
   assign m2_a[0] = {e_ctx.t[W-1], e_ctx.t};
   assign m2_b[0] = {spiky_ff[W-1], spiky_ff};
   assign m2_a[1] = {e_ctx.u[W-1], e_ctx.u};
   assign m2_b[1] = {visc_lap_ff[W-1], visc_lap_ff};

   sphf_mulq #(.LANES(2), .SIDE_W(CW)) u_mul2 (
      .clock(clock), .reset(reset), .in_valid(d1_valid), .in_a(m2_a), .in_b(m2_b),
      .in_side(e_ctx), .out_valid(m2_valid), .out_res(m2_r), .out_side(m2_ctx)
   );

   always_comb begin
      f_ctx   = m2_ctx;
      f_ctx.t = m2_r[0];
      f_ctx.u = m2_r[1];
   end

   // first range factor on both terms
   assign m3_a[0] = {f_ctx.t[W-1], f_ctx.t};
   assign m3_b[0] = {f_ctx.rmd[W-1], f_ctx.rmd};
   assign m3_a[1] = {f_ctx.u[W-1], f_ctx.u};
   assign m3_b[1] = {f_ctx.rmd[W-1], f_ctx.rmd};

   sphf_mulq #(.LANES(2), .SIDE_W(CW)) u_mul3 (
      .clock(clock), .reset(reset), .in_valid(m2_valid), .in_a(m3_a), .in_b(m3_b),
      .in_side(f_ctx), .out_valid(m3_valid), .out_res(m3_r), .out_side(m3_ctx)
   );

   always_comb begin
      g_ctx   = m3_ctx;
      g_ctx.t = m3_r[0];
      g_ctx.u = m3_r[1];
   end

   // second range factor, pressure term only
   assign m4_a[0] = {g_ctx.t[W-1], g_ctx.t};
   assign m4_b[0] = {g_ctx.rmd[W-1], g_ctx.rmd};

   sphf_mulq #(.LANES(1), .SIDE_W(CW)) u_mul4 (
      .clock(clock), .reset(reset), .in_valid(m3_valid), .in_a(m4_a), .in_b(m4_b),
      .in_side(g_ctx), .out_valid(m4_valid), .out_res(m4_r), .out_side(m4_ctx)
   );

   always_comb begin
      h_ctx   = m4_ctx;
      h_ctx.t = m4_r[0];
   end

   // pressure over distance, viscosity over neighbor density
   assign dv_a[0] = h_ctx.t;
   assign dv_d[0] = {1'b0, h_ctx.root_dist};
   assign dv_a[1] = h_ctx.u;
   assign dv_d[1] = {1'b0, h_ctx.rho_nb};

   sphf_divq #(.LANES(2), .SIDE_W(CW)) u_div2 (
      .clock(clock), .reset(reset), .in_valid(m4_valid), .in_a(dv_a), .in_d(dv_d),
      .in_side(h_ctx), .out_valid(d2_valid), .out_res(dv_r), .out_side(dv_ctx)
   );

   always_comb begin
      i_ctx   = dv_ctx;
      i_ctx.t = dv_r[0];
      i_ctx.u = dv_r[1];
   end

   // components along position and velocity
   assign m5_a[0] = {i_ctx.t[W-1], i_ctx.t};
   assign m5_b[0] = {i_ctx.px[W-1], i_ctx.px};
   assign m5_a[1] = {i_ctx.t[W-1], i_ctx.t};
   assign m5_b[1] = {i_ctx.py[W-1], i_ctx.py};
   assign m5_a[2] = {i_ctx.u[W-1], i_ctx.u};
   assign m5_b[2] = {i_ctx.vx[W-1], i_ctx.vx};
   assign m5_a[3] = {i_ctx.u[W-1], i_ctx.u};
   assign m5_b[3] = {i_ctx.vy[W-1], i_ctx.vy};

   sphf_mulq #(.LANES(4), .SIDE_W(CW)) u_mul5 (
      .clock(clock), .reset(reset), .in_valid(d2_valid), .in_a(m5_a), .in_b(m5_b),
      .in_side(i_ctx), .out_valid(m5_valid), .out_res(m5_r), .out_side(m5_ctx)
   );

   // drop inactive terms, saturating sum
   always_comb begin
      ax    = m5_ctx.pon ? m5_r[0] : '0;
      ay    = m5_ctx.pon ? m5_r[1] : '0;
      bx    = m5_ctx.von ? m5_r[2] : '0;
      by    = m5_ctx.von ? m5_r[3] : '0;
      sx    = {ax[W-1], ax} + {bx[W-1], bx};
      sy    = {ay[W-1], ay} + {by[W-1], by};
      j_ctx = m5_ctx;
      if (sx[W] != sx[W-1]) begin
         j_ctx.t = sx[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         j_ctx.t = sx[W-1:0];
      end
      if (sy[W] != sy[W-1]) begin
         j_ctx.u = sy[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         j_ctx.u = sy[W-1:0];
      end
   end

   // divide by own density
   assign d3_a[0] = j_ctx.t;
   assign d3_d[0] = {1'b0, j_ctx.rho_own};
   assign d3_a[1] = j_ctx.u;
   assign d3_d[1] = {1'b0, j_ctx.rho_own};

   sphf_divq #(.LANES(2), .SIDE_W(CW)) u_div3 (
      .clock(clock), .reset(reset), .in_valid(m5_valid), .in_a(d3_a), .in_d(d3_d),
      .in_side(j_ctx), .out_valid(d3_valid), .out_res(d3_r), .out_side(d3_ctx)
   );

   // result register
   always_comb begin
      rsp_item_in.status = d3_ctx.status;
      if (d3_ctx.status == sphf_pkg::STATUS_OK) begin
         rsp_item_in.force_x = d3_r[0];
         rsp_item_in.force_y = d3_r[1];
      end else begin
         rsp_item_in.force_x = '0;
         rsp_item_in.force_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d3_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the sph pair pressure and viscosity force block
// depends on sphf_pkg and sph_pair_pressure_viscosity_force; drives pairs through
// a directed table and random phases, and checks results against a force model

module testbench;

   localparam int WB       = sphf_pkg::WORD_BITS;
   localparam int FB       = sphf_pkg::FRAC_BITS;
   localparam int REQ_BITS = $bits(sphf_pkg::req_type);

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   sphf_pkg::req_type req_item;
   logic              rsp_valid;
   sphf_pkg::rsp_type rsp_item;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [WB-1:0]     csr_data;

   // force model registers
   longint unsigned range_q;
   longint          grad_coef_q;
   longint          lap_coef_q;
   longint          visc_q;

   sphf_pkg::rsp_type force_queue[$];
   int                error_count;
   bit                allow_gaps;

   typedef struct {
      sphf_pkg::req_type pair;
      bit                typed;
      sphf_pkg::rsp_type want;
   } pair_row_type;

   pair_row_type pair_table[$];

   sph_pair_pressure_viscosity_force uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // fixed-point helpers
   function automatic logic [127:0] magnitude(longint v);
      return (v < 0) ? 128'(-v) : 128'(v);
   endfunction

   function automatic longint clamp_word(bit neg, logic [127:0] m);
      logic [127:0] lim;
      lim = (128'd1 << (WB - 1)) - (neg ? 128'd0 : 128'd1);
      if (m > lim) m = lim;
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return clamp_word((a < 0) != (b < 0), (magnitude(a) * magnitude(b)) >> FB);
   endfunction

   function automatic longint fx_div(longint a, longint unsigned d);
      return clamp_word(a < 0, (magnitude(a) << FB) / 128'(d));
   endfunction

   function automatic longint unsigned floor_sqrt(logic [127:0] n);
      logic [127:0] r;
      logic [127:0] c;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= n) r = c;
      end
      return r[63:0];
   endfunction

   // expected force for one pair under the current registers
   function automatic sphf_pkg::rsp_type pair_force(sphf_pkg::req_type p);
      sphf_pkg::rsp_type f;
      longint           px, py, vx, vy, p_own, p_nb, rmd, t, u, ax, ay;
      longint unsigned  mass, rho_own, rho_nb, root_dist;
      logic [127:0]     d2;
      bit               pon, von;
      px = longint'(p.rel_pos_x);
      py = longint'(p.rel_pos_y);
      vx = longint'(p.rel_vel_x);
      vy = longint'(p.rel_vel_y);
      p_own = longint'(p.own_pressure);
      p_nb = longint'(p.neighbor_pressure);
      mass = p.neighbor_mass;
      rho_own = p.own_density;
      rho_nb = p.neighbor_density;
      f.force_x = '0;
      f.force_y = '0;
      f.status = sphf_pkg::STATUS_OK;
      d2 = magnitude(px) * magnitude(px) + magnitude(py) * magnitude(py);
      if (p.neighbor_is_boundary || d2 >= 128'(range_q) * 128'(range_q)) begin
         f.status = sphf_pkg::STATUS_SKIP;
         return f;
      end
      pon = p_own > 0;
      von = visc_q > 0;
      root_dist = floor_sqrt(d2);
      rmd = longint'(range_q) - longint'(root_dist);
      if (rho_own == 0 || ((pon || von) && rho_nb == 0) || (pon && root_dist == 0)) begin
         f.status = sphf_pkg::STATUS_FAULT;
         return f;
      end
      ax = 0;
      ay = 0;
      // spiky pressure term
      if (pon) begin
         t = fx_mul(longint'(mass), p_own + p_nb);
         t = fx_div(t, 2 * rho_nb);
         t = fx_mul(t, grad_coef_q);
         t = fx_mul(t, rmd);
         t = fx_mul(t, rmd);
         t = fx_div(t, root_dist);
         ax = fx_mul(t, px);
         ay = fx_mul(t, py);
      end
      // viscosity term
      if (von) begin
         u = fx_mul(visc_q, longint'(mass));
         u = fx_mul(u, lap_coef_q);
         u = fx_mul(u, rmd);
         u = fx_div(u, rho_nb);
         ax = clamp_word(ax + fx_mul(u, vx) < 0, magnitude(ax + fx_mul(u, vx)));
         ay = clamp_word(ay + fx_mul(u, vy) < 0, magnitude(ay + fx_mul(u, vy)));
      end
      f.force_x = WB'(fx_div(ax, rho_own));
      f.force_y = WB'(fx_div(ay, rho_own));
      return f;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // result checker: every strobe is one accepted transfer
   always @(posedge clock) begin
      sphf_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (force_queue.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_item.status, -1);
         end else begin
            want = force_queue.pop_front();
            if (rsp_item.force_x !== want.force_x)
               report_mismatch("force_x", rsp_item.force_x, want.force_x);
            if (rsp_item.force_y !== want.force_y)
               report_mismatch("force_y", rsp_item.force_y, want.force_y);
            if (rsp_item.status !== want.status)
               report_mismatch("status", rsp_item.status, want.status);
         end
      end
   end

   function automatic sphf_pkg::req_type make_pair(longint px, longint py, longint vx,
                                                   longint vy, longint m, longint po,
                                                   longint pn, longint ro, longint rn,
                                                   bit bnd);
      sphf_pkg::req_type p;
      p.rel_pos_x = WB'(px);
      p.rel_pos_y = WB'(py);
      p.rel_vel_x = WB'(vx);
      p.rel_vel_y = WB'(vy);
      p.neighbor_mass = (WB-1)'(m);
      p.own_pressure = WB'(po);
      p.neighbor_pressure = WB'(pn);
      p.own_density = (WB-1)'(ro);
      p.neighbor_density = (WB-1)'(rn);
      p.neighbor_is_boundary = bnd;
      return p;
   endfunction

   function automatic sphf_pkg::rsp_type zero_force(logic [1:0] st);
      sphf_pkg::rsp_type f;
      f.force_x = '0;
      f.force_y = '0;
      f.status = st;
      return f;
   endfunction

   task automatic add_row(sphf_pkg::req_type p, bit typed, sphf_pkg::rsp_type want);
      pair_row_type row;
      row.pair = p;
      row.typed = typed;
      row.want = want;
      pair_table.push_back(row);
   endtask

   // one pair transfer, optionally preceded by an idle burst
   task automatic send_pair(sphf_pkg::req_type p, bit typed, sphf_pkg::rsp_type want);
      int gap;
      if (allow_gaps && $urandom_range(3, 0) == 0) begin
         gap = $urandom_range(15, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= p;
      do @(posedge clock); while (busy);
      force_queue.push_back(typed ? want : pair_force(p));
   endtask

   // one register transfer; the caller lowers csr_valid after the last one
   task automatic write_reg(logic [1:0] idx, longint value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= WB'(value);
      do @(posedge clock); while (!csr_ready);
      case (idx)
         sphf_pkg::REG_KERNEL_RANGE: range_q = value & 64'h7FFF_FFFF;
         sphf_pkg::REG_SPIKY_GRAD:   grad_coef_q = longint'(signed'(WB'(value)));
         sphf_pkg::REG_VISC_LAP:     lap_coef_q = longint'(signed'(WB'(value)));
         default:                    visc_q = longint'(signed'(WB'(value)));
      endcase
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (force_queue.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   function automatic longint signed_coord(longint unsigned lim);
      longint unsigned m;
      m = $urandom_range(32'(lim), 0);
      return $urandom_range(1, 0) ? -longint'(m) : longint'(m);
   endfunction

   // random pair: mostly in range with plausible values, some noise
   function automatic sphf_pkg::req_type random_pair();
      sphf_pkg::req_type p;
      longint unsigned   lim;
      int                kind;
      kind = $urandom_range(99, 0);
      if (kind < 12) begin
         p = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, 1'($urandom)});
         return p;
      end
      lim = (range_q > 64'h6000_0000) ? 64'h7FFF_FFFF : range_q + range_q / 4 + 1;
      p = make_pair(signed_coord(lim), signed_coord(lim),
                    signed_coord(64'h0004_0000), signed_coord(64'h0004_0000),
                    $urandom_range(32'h0002_0000, 0),
                    signed_coord(64'h0008_0000), signed_coord(64'h0008_0000),
                    $urandom_range(32'h0003_0000, 32'h0000_4000),
                    $urandom_range(32'h0003_0000, 32'h0000_4000), kind < 17);
      if (kind >= 17 && kind < 21) p.own_density = '0;
      if (kind >= 21 && kind < 25) p.neighbor_density = '0;
      return p;
   endfunction

   // register settings per random phase: range, gradient, laplacian, viscosity
   longint phase_regs[6][4] = '{
      '{65536, -625824, 258958, 131072},
      '{64'h7FFF_FFFF, 64'h7FFF_FFFF, -64'sh8000_0000, 64'h7FFF_FFFF},
      '{0, -1, 1, -5},
      '{32768, -64'sh8000_0000, 64'h7FFF_FFFF, 1},
      '{262144, -625824, 258958, 12288},
      '{65536, -625824, 258958, 65536}
   };

   // main stimulus
   initial begin
      sphf_pkg::rsp_type none;
      none = zero_force(sphf_pkg::STATUS_OK);
      error_count = 0;
      allow_gaps = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_index = sphf_pkg::REG_KERNEL_RANGE;
      csr_data = '0;
      range_q = 65536;
      grad_coef_q = -625824;
      lap_coef_q = 258958;
      visc_q = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under reset register values
      add_row(make_pair(16384, 0, 0, 0, 65536, 65536, 65536, 65536, 65536, 1'b1),
              1'b1, zero_force(sphf_pkg::STATUS_SKIP));
      add_row(make_pair(64'h7FFF_FFFF, 0, 0, 0, 65536, 65536, 65536, 65536, 65536, 1'b0),
              1'b1, zero_force(sphf_pkg::STATUS_SKIP));
      add_row(make_pair(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                        64'h7FFF_FFFF, 64'h7FFF_FFFF, -64'sh8000_0000, 64'h7FFF_FFFF,
                        64'h7FFF_FFFF, 64'h7FFF_FFFF, 1'b0),
              1'b1, zero_force(sphf_pkg::STATUS_SKIP));
      add_row(make_pair(65536, 0, 0, 0, 65536, 65536, 65536, 65536, 65536, 1'b0),
              1'b1, zero_force(sphf_pkg::STATUS_SKIP));
      add_row(make_pair(16384, 0, 0, 0, 65536, 65536, 65536, 0, 65536, 1'b0),
              1'b1, zero_force(sphf_pkg::STATUS_FAULT));
      add_row(make_pair(0, 0, 0, 0, 65536, 65536, 65536, 65536, 65536, 1'b0),
              1'b1, zero_force(sphf_pkg::STATUS_FAULT));
      add_row(make_pair(16384, 0, 0, 0, 65536, 65536, 65536, 65536, 0, 1'b0),
              1'b1, zero_force(sphf_pkg::STATUS_FAULT));
      add_row(make_pair(16384, 8192, 100, 100, 65536, -65536, 65536, 65536, 65536, 1'b0),
              1'b1, none);
      add_row(make_pair(0, 0, 0, 0, 65536, 0, 65536, 65536, 0, 1'b0), 1'b1, none);
      add_row(make_pair(16384, -8192, 0, 0, 65536, 131072, 65536, 65536, 65536, 1'b0),
              1'b0, none);
      add_row(make_pair(-20000, 30000, 0, 0, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
                        1, 1, 1'b0), 1'b0, none);
      add_row(make_pair(40000, 1000, 0, 0, 65536, 1, -64'sh8000_0000, 65536, 65536, 1'b0),
              1'b0, none);
      add_row(make_pair(-1000, -40000, 0, 0, 98304, 65536, 0,
                        64'h7FFF_FFFF, 64'h7FFF_FFFF, 1'b0), 1'b0, none);
      add_row(make_pair(-1, 0, 0, 0, 65536, 65536, 65536, 65536, 65536, 1'b0), 1'b0, none);
      foreach (pair_table[i])
         send_pair(pair_table[i].pair, pair_table[i].typed, pair_table[i].want);

      // random phases, each under its own register setting
      for (int ph = 0; ph < 6; ph++) begin
         drain_results();
         write_reg(sphf_pkg::REG_KERNEL_RANGE, phase_regs[ph][0]);
         write_reg(sphf_pkg::REG_SPIKY_GRAD, phase_regs[ph][1]);
         write_reg(sphf_pkg::REG_VISC_LAP, phase_regs[ph][2]);
         write_reg(sphf_pkg::REG_VISCOSITY, phase_regs[ph][3]);
         csr_valid <= 1'b0;
         allow_gaps = (ph < 5);
         repeat (100) send_pair(random_pair(), 1'b0, none);
      end
      start <= 1'b0;

      // wait out the pipeline
      while (force_queue.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // run limit
   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
